### hdl/hpp_pkg.sv
// ----------------------------------------------------------------------------
// hpp_pkg
// Shared types and constants of the homography point projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package hpp_pkg;

  // Fixed field widths of the item payloads and the register file.
  localparam int POINT_BITS = 13;
  localparam int COEF_BITS  = 32;
  localparam int QBITS      = 32;
  localparam int CFG_BITS   = 64;
  localparam int IDX_BITS   = 3;

  // Register indexes of the configuration port.
  typedef enum logic [IDX_BITS-1:0] {
    CFG_H00_H01 = 3'd0,
    CFG_H02_H10 = 3'd1,
    CFG_H11_H12 = 3'd2,
    CFG_H20_H21 = 3'd3,
    CFG_H22     = 3'd4
  } cfg_idx_t;

  // Input item: one source pixel.
  typedef struct packed {
    logic [POINT_BITS-1:0] point_x;
    logic [POINT_BITS-1:0] point_y;
  } point_t;

  // Result item: projected point and error flag.
  typedef struct packed {
    logic signed [QBITS-1:0] proj_x;
    logic signed [QBITS-1:0] proj_y;
    logic                    proj_invalid;
  } proj_t;

  // Per-item flags that travel alongside the dividers.
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic zero_z;
    logic ovf_x;
    logic ovf_y;
  } side_t;

endpackage

`default_nettype wire

### hdl/hpp_div_pipe.sv
// ----------------------------------------------------------------------------
// hpp_div_pipe
// Pipelined restoring divider: one quotient bit per register stage, giving
// floor(n * 2^FRAC_BITS / d) on 32 bits, for n < d * 2^(32 - FRAC_BITS).
// ----------------------------------------------------------------------------
`default_nettype none

module hpp_div_pipe #(
  parameter int SW        = 48,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [SW-1:0]          n,
  input  wire logic [SW-1:0]          d,
  output logic [hpp_pkg::QBITS-1:0]   q
);
  import hpp_pkg::*;

  localparam int K = QBITS - FRAC_BITS;

  logic [SW-1:0]    r_s  [0:QBITS];
  logic [SW-1:0]    d_s  [0:QBITS];
  logic [QBITS-1:0] lo_s [0:QBITS];
  logic [QBITS-1:0] q_s  [0:QBITS];

  // The high part of the shifted dividend is the starting remainder.
  assign r_s[0]  = n >> K;
  assign d_s[0]  = d;
  assign lo_s[0] = {n[K-1:0], {FRAC_BITS{1'b0}}};
  assign q_s[0]  = '0;

  for (genvar i = 0; i < QBITS; i++) begin : g_step
    logic [SW:0]   rs;
    logic [SW:0]   diff;
    logic          ge;
    logic [SW-1:0] nr;

    // Bring in the next dividend bit and try a subtraction.
    always_comb begin
      rs   = {r_s[i], lo_s[i][QBITS-1]};
      diff = rs - {1'b0, d_s[i]};
      ge   = (rs >= {1'b0, d_s[i]});
      nr   = ge ? diff[SW-1:0] : rs[SW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_s[i+1]  <= nr;
        d_s[i+1]  <= d_s[i];
        lo_s[i+1] <= {lo_s[i][QBITS-2:0], 1'b0};
        q_s[i+1]  <= {q_s[i][QBITS-2:0], ge};
      end
    end
  end

  assign q = q_s[QBITS];

endmodule

`default_nettype wire

### hdl/homography_point_projection_top.sv
// ----------------------------------------------------------------------------
// homography_point_projection_top
// Projects an integer pixel point through a 3x3 Q16.16 homography and
// returns (X/Z, Y/Z) in Q16.16 with saturation and an invalid flag.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    point_t (point_x, point_y)
//   out      output     out_valid / out_ready  proj_t (proj_x, proj_y, proj_invalid)
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// One item enters per cycle unless the output stalls; it passes 36 register
// stages (multiply, sum, magnitude, 32 divider stages of one quotient bit
// each, output register) on the way to its result.
// The 32-stage divider is pipelined; throughput is one item per clock unless out_ready stalls it.
// Synchronous reset clears all valid bits and loads the identity matrix.
// The whole pipeline holds when a result waits and out_ready is low.
`default_nettype none

module homography_point_projection_top #(
  parameter int COORD_BITS = 13,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire hpp_pkg::point_t                 in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output hpp_pkg::proj_t                       out_data,
  input  wire logic                            cfg_we,
  input  wire logic [hpp_pkg::IDX_BITS-1:0]    cfg_index,
  input  wire logic [hpp_pkg::CFG_BITS-1:0]    cfg_data
);
  import hpp_pkg::*;

  localparam int CW = (COORD_BITS < POINT_BITS) ? COORD_BITS : POINT_BITS;
  localparam int PW = COEF_BITS + CW + 1;
  localparam int SW = PW + 2;
  localparam logic [COEF_BITS-1:0] FIX_ONE = COEF_BITS'(1) << FRAC_BITS;
  localparam logic [QBITS-1:0] LIM_POS = {1'b0, {(QBITS-1){1'b1}}};
  localparam logic [QBITS-1:0] LIM_NEG = {1'b1, {(QBITS-1){1'b0}}};

  // Configuration registers.
  logic [CFG_BITS-1:0]  reg_h00_h01, reg_h02_h10, reg_h11_h12, reg_h20_h21;
  logic [COEF_BITS-1:0] reg_h22;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_h00_h01 <= {FIX_ONE, {COEF_BITS{1'b0}}};
      reg_h02_h10 <= '0;
      reg_h11_h12 <= {FIX_ONE, {COEF_BITS{1'b0}}};
      reg_h20_h21 <= '0;
      reg_h22     <= FIX_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_H00_H01: reg_h00_h01 <= cfg_data;
        CFG_H02_H10: reg_h02_h10 <= cfg_data;
        CFG_H11_H12: reg_h11_h12 <= cfg_data;
        CFG_H20_H21: reg_h20_h21 <= cfg_data;
        CFG_H22:     reg_h22     <= cfg_data[COEF_BITS-1:0];
        default:     ;
      endcase
    end
  end

  logic signed [COEF_BITS-1:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;
  assign h00 = reg_h00_h01[CFG_BITS-1:COEF_BITS];
  assign h01 = reg_h00_h01[COEF_BITS-1:0];
  assign h02 = reg_h02_h10[CFG_BITS-1:COEF_BITS];
  assign h10 = reg_h02_h10[COEF_BITS-1:0];
  assign h11 = reg_h11_h12[CFG_BITS-1:COEF_BITS];
  assign h12 = reg_h11_h12[COEF_BITS-1:0];
  assign h20 = reg_h20_h21[CFG_BITS-1:COEF_BITS];
  assign h21 = reg_h20_h21[COEF_BITS-1:0];
  assign h22 = reg_h22;

  // Pipeline advance: everything moves unless the output is blocked.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Stage 1: six coefficient products.
  logic signed [CW:0]   cx, cy;
  logic signed [PW-1:0] p00, p01, p10, p11, p20, p21;
  logic                 v1;

  assign cx = $signed({1'b0, in_data.point_x[CW-1:0]});
  assign cy = $signed({1'b0, in_data.point_y[CW-1:0]});

  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= h00 * cx;
      p01 <= h01 * cy;
      p10 <= h10 * cx;
      p11 <= h11 * cy;
      p20 <= h20 * cx;
      p21 <= h21 * cy;
    end
  end

  // Stage 2: the three homogeneous coordinates.
  logic signed [SW-1:0] sx, sy, sz;
  logic                 v2;

  always_ff @(posedge clk) begin
    if (en) begin
      sx <= SW'(p00) + SW'(p01) + SW'(h02);
      sy <= SW'(p10) + SW'(p11) + SW'(h12);
      sz <= SW'(p20) + SW'(p21) + SW'(h22);
    end
  end

  // Stage 3: magnitudes, signs and the early overflow test.
  logic [SW-1:0] ax, ay, az;
  logic [SW-1:0] nx, ny, dz;
  side_t         side3;
  logic          v3;

  always_comb begin
    ax = sx[SW-1] ? (~sx + SW'(1)) : sx;
    ay = sy[SW-1] ? (~sy + SW'(1)) : sy;
    az = sz[SW-1] ? (~sz + SW'(1)) : sz;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx           <= ax;
      ny           <= ay;
      dz           <= az;
      side3.neg_x  <= sx[SW-1] ^ sz[SW-1];
      side3.neg_y  <= sy[SW-1] ^ sz[SW-1];
      side3.zero_z <= (sz == '0);
      side3.ovf_x  <= ((ax >> (QBITS - FRAC_BITS)) >= az);
      side3.ovf_y  <= ((ay >> (QBITS - FRAC_BITS)) >= az);
    end
  end

  // Divider stages for both quotients.
  logic [QBITS-1:0] qx, qy;

  hpp_div_pipe #(.SW(SW), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk(clk), .en(en), .n(nx), .d(dz), .q(qx)
  );

  hpp_div_pipe #(.SW(SW), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk(clk), .en(en), .n(ny), .d(dz), .q(qy)
  );

  // Flags and valid bits follow the divider stages.
  side_t side_d [0:QBITS-1];
  logic  vd     [0:QBITS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      side_d[0] <= side3;
      for (int i = 1; i < QBITS; i++) side_d[i] <= side_d[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      for (int i = 0; i < QBITS; i++) vd[i] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      v2    <= v1;
      v3    <= v2;
      vd[0] <= v3;
      for (int i = 1; i < QBITS; i++) vd[i] <= vd[i-1];
      out_valid <= vd[QBITS-1];
    end
  end

  // Final saturation, sign and zero-denominator handling.
  side_t            sf;
  logic [QBITS-1:0] lim_x, lim_y, mx, my;
  logic             bad_x, bad_y;
  proj_t            res;

  always_comb begin
    sf    = side_d[QBITS-1];
    lim_x = sf.neg_x ? LIM_NEG : LIM_POS;
    lim_y = sf.neg_y ? LIM_NEG : LIM_POS;
    bad_x = sf.ovf_x || (qx > lim_x);
    bad_y = sf.ovf_y || (qy > lim_y);
    mx    = bad_x ? lim_x : qx;
    my    = bad_y ? lim_y : qy;
    if (sf.zero_z) begin
      res.proj_x       = '0;
      res.proj_y       = '0;
      res.proj_invalid = 1'b1;
    end else begin
      res.proj_x       = sf.neg_x ? -mx : mx;
      res.proj_y       = sf.neg_y ? -my : my;
      res.proj_invalid = bad_x || bad_y;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

### hdl/hpp_checker.sv
// ----------------------------------------------------------------------------
// hpp_checker
// Port-level checks of the projection block, attached to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hpp_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire hpp_pkg::proj_t out_data
);

  // No item comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A waiting result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The block only refuses items while a result is blocked.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled without output back-pressure");

  // A refused input always has a waiting result behind it.
  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stall without a waiting result");

endmodule

bind homography_point_projection_top hpp_checker u_hpp_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_data(out_data)
);

`default_nettype wire
